// ===== hdl/renc_pkg.sv =====
package renc_pkg;

  localparam int unsigned MASK_W = 8;
  localparam int unsigned TICK_W = 32;
  localparam int unsigned POS_W = 32;
  localparam int unsigned COUNT_W = 4;

  localparam logic [POS_W-1:0] POS_RESET = 32'h7FFF_FFFF;
  localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 32'd20;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

  // configuration register indexes
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  typedef struct packed {
    logic a_rise;
    logic a_fall;
    logic b_rise;
    logic b_fall;
    logic b_level;
    logic [MASK_W-1:0] sw_rise_mask;
    logic [MASK_W-1:0] sw_fall_mask;
    logic [TICK_W-1:0] now_tick;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [MASK_W-1:0] switch_levels;
  } out_item_t;

endpackage

// ===== hdl/rotary_encoder_with_switch_debounce.sv =====
// Quadrature encoder decoder with debounced push switches.
// Input channel (in_valid/in_ready/in_data) takes one pin-event item: encoder
// A/B edge flags, the B level, rise/fall masks for the switch slots and the
// current tick. Result channel (out_valid/out_ready/out_data) returns one item
// per input: the position counter and the debounced switch levels.
// An accepted item sits in an input register; it is applied to the encoder
// and switch state once the result slot is free, and those registers drive out_data.
// out_valid rises when the state registers take the item, and one item per cycle
// is taken when the receiver keeps out_ready high. The rate is set by the
// update of the state registers.
// When the receiver stalls, the result holds and one more item waits in the
// input register; after that in_ready drops until the result is taken.
// Configuration (cfg_we/cfg_index/cfg_wdata) writes debounce_ticks (index 0)
// and switch_count (index 1) and is meant to be used while the block is idle.
// Reset (rst_n low, synchronous) sets position to 0x7FFFFFFF, clears the arm
// flag, the switch levels and stamps, and loads debounce 20 and count 8.
module rotary_encoder_with_switch_debounce #(
  parameter int NUM_SWITCHES = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  renc_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output renc_pkg::out_item_t out_data,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [renc_pkg::TICK_W-1:0] cfg_wdata
);

  logic in_valid_r, in_valid_nxt;
  renc_pkg::in_item_t in_data_r;
  logic out_valid_r, out_valid_nxt;
  logic [renc_pkg::TICK_W-1:0] debounce_r;
  logic [renc_pkg::COUNT_W-1:0] count_r;
  logic step;
  logic [renc_pkg::POS_W-1:0] position;
  logic [renc_pkg::MASK_W-1:0] levels;

  // the held item is applied once the result slot is free
  assign step = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= renc_pkg::DEBOUNCE_RESET;
      count_r <= renc_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        renc_pkg::REG_DEBOUNCE: debounce_r <= cfg_wdata;
        renc_pkg::REG_COUNT: count_r <= cfg_wdata[renc_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  renc_quad u_quad (
    .clk(clk),
    .rst_n(rst_n),
    .step(step),
    .item(in_data_r),
    .position(position)
  );

  renc_debounce #(
    .NUM_SWITCHES(NUM_SWITCHES)
  ) u_debounce (
    .clk(clk),
    .rst_n(rst_n),
    .step(step),
    .rise_mask(in_data_r.sw_rise_mask),
    .fall_mask(in_data_r.sw_fall_mask),
    .now_tick(in_data_r.now_tick),
    .debounce_ticks(debounce_r),
    .switch_count(count_r),
    .levels(levels)
  );

  assign out_valid = out_valid_r;
  assign out_data.position = position;
  assign out_data.switch_levels = levels;

endmodule

// ===== hdl/renc_quad.sv =====
module renc_quad (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  renc_pkg::in_item_t item,
  output logic [renc_pkg::POS_W-1:0] position
);

  logic [renc_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic armed_r, armed_nxt;

  always_comb begin
    pos_nxt = pos_r;
    armed_nxt = armed_r;
    // only the first pending edge acts: A rise, A fall, B rise, B fall
    if (item.a_rise) begin
      if (armed_r) begin
        pos_nxt = item.b_level ? pos_r - 1'b1 : pos_r + 1'b1;
      end
      armed_nxt = 1'b0;
    end else if (item.a_fall) begin
      if (armed_r) begin
        pos_nxt = item.b_level ? pos_r + 1'b1 : pos_r - 1'b1;
      end
      armed_nxt = 1'b0;
    end else if (item.b_rise || item.b_fall) begin
      armed_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= renc_pkg::POS_RESET;
      armed_r <= 1'b0;
    end else if (step) begin
      pos_r <= pos_nxt;
      armed_r <= armed_nxt;
    end
  end

  assign position = pos_r;

endmodule

// ===== hdl/renc_debounce.sv =====
module renc_debounce #(
  parameter int NUM_SWITCHES = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  logic [renc_pkg::MASK_W-1:0] rise_mask,
  input  logic [renc_pkg::MASK_W-1:0] fall_mask,
  input  logic [renc_pkg::TICK_W-1:0] now_tick,
  input  logic [renc_pkg::TICK_W-1:0] debounce_ticks,
  input  logic [renc_pkg::COUNT_W-1:0] switch_count,
  output logic [renc_pkg::MASK_W-1:0] levels
);

  logic [NUM_SWITCHES-1:0] state_r, state_nxt;
  logic [renc_pkg::TICK_W-1:0] stamp_r [NUM_SWITCHES];
  logic [renc_pkg::TICK_W-1:0] stamp_nxt [NUM_SWITCHES];

  for (genvar c = 0; c < NUM_SWITCHES; c++) begin : g_slot
    logic r, f, en, hit;
    logic [renc_pkg::TICK_W-1:0] limit;

    // slots past the mask width have no edge bits
    if (c < int'(renc_pkg::MASK_W)) begin : g_edge
      assign r = rise_mask[c];
      assign f = fall_mask[c];
    end else begin : g_noedge
      assign r = 1'b0;
      assign f = 1'b0;
    end

    always_comb begin
      en = int'(switch_count) > c;
      limit = stamp_r[c] + debounce_ticks;
      hit = en && (r || f) && (limit < now_tick);
      state_nxt[c] = hit ? !r : state_r[c];
      stamp_nxt[c] = hit ? now_tick : stamp_r[c];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        state_r[c] <= 1'b0;
        stamp_r[c] <= '0;
      end else if (step) begin
        state_r[c] <= state_nxt[c];
        stamp_r[c] <= stamp_nxt[c];
      end
    end
  end

  for (genvar c = 0; c < int'(renc_pkg::MASK_W); c++) begin : g_level
    if (c < NUM_SWITCHES) begin : g_live
      assign levels[c] = state_r[c];
    end else begin : g_dead
      assign levels[c] = 1'b0;
    end
  end

endmodule

// ===== sim/tb_rotary_encoder_with_switch_debounce.sv =====
module tb_rotary_encoder_with_switch_debounce;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = 8;

  // encoder flag patterns, packed as {a_rise, a_fall, b_rise, b_fall, b_level}
  localparam logic [4:0] EV_NONE   = 5'b00000;
  localparam logic [4:0] EV_A_RISE = 5'b10000;
  localparam logic [4:0] EV_A_FALL = 5'b01000;
  localparam logic [4:0] EV_B_RISE = 5'b00100;
  localparam logic [4:0] EV_B_FALL = 5'b00010;
  localparam logic [4:0] EV_B_HIGH = 5'b00001;

  localparam logic [renc_pkg::TICK_W-1:0] TICK_MAX = 32'hFFFF_FFFF;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  renc_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  renc_pkg::out_item_t out_data;
  logic cfg_we;
  logic cfg_index;
  logic [renc_pkg::TICK_W-1:0] cfg_wdata;

  // predictor copy of the block state and registers
  logic [renc_pkg::POS_W-1:0] knob_pos;
  logic knob_armed;
  logic [SLOTS-1:0] slot_level;
  logic [renc_pkg::TICK_W-1:0] slot_stamp [SLOTS];
  logic [renc_pkg::TICK_W-1:0] window_ticks;
  logic [renc_pkg::COUNT_W-1:0] live_slots;

  renc_pkg::out_item_t readings_due [$];
  int errors = 0;
  bit no_idle = 1'b0;
  logic [renc_pkg::TICK_W-1:0] tick_now = '0;

  rotary_encoder_with_switch_debounce DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic renc_pkg::out_item_t advance_knob(input renc_pkg::in_item_t ev);
    renc_pkg::out_item_t res;
    int unsigned n;
    logic [renc_pkg::TICK_W-1:0] limit;
    if (ev.a_rise) begin
      if (knob_armed) knob_pos = ev.b_level ? knob_pos - 32'd1 : knob_pos + 32'd1;
      knob_armed = 1'b0;
    end else if (ev.a_fall) begin
      if (knob_armed) knob_pos = ev.b_level ? knob_pos + 32'd1 : knob_pos - 32'd1;
      knob_armed = 1'b0;
    end else if (ev.b_rise || ev.b_fall) begin
      knob_armed = 1'b1;
    end
    n = (live_slots > SLOTS) ? SLOTS : live_slots;
    for (int c = 0; c < n; c++) begin
      if (ev.sw_rise_mask[c] || ev.sw_fall_mask[c]) begin
        limit = slot_stamp[c] + window_ticks;
        if (limit < ev.now_tick) begin
          // rise wins over fall on the same slot
          slot_level[c] = ev.sw_rise_mask[c] ? 1'b0 : 1'b1;
          slot_stamp[c] = ev.now_tick;
        end
      end
    end
    res.position = knob_pos;
    res.switch_levels = slot_level;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    errors++;
    $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
  endtask

  always @(negedge clk) out_ready <= no_idle || ($urandom_range(99) >= 8);

  always @(posedge clk) begin : check_results
    renc_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (readings_due.size() == 0) begin
        report_mismatch("unexpected item", '0, out_data.position);
      end else begin
        want = readings_due.pop_front();
        if (out_data.position !== want.position)
          report_mismatch("position", want.position, out_data.position);
        if (out_data.switch_levels !== want.switch_levels)
          report_mismatch("switch_levels", 32'(want.switch_levels),
                          32'(out_data.switch_levels));
      end
    end
  end

  // entered and left at a falling edge; in_valid stays high after return
  task automatic send_pin_event(input renc_pkg::in_item_t ev);
    int gap;
    if (!no_idle && $urandom_range(99) < 4) begin
      in_valid <= 1'b0;
      gap = $urandom_range(3, 1);
      repeat (gap) @(negedge clk);
    end
    in_data <= ev;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    readings_due.push_back(advance_knob(ev));
    @(negedge clk);
  endtask

  task automatic send_flags(input logic [4:0] flags,
                            input logic [renc_pkg::MASK_W-1:0] rise,
                            input logic [renc_pkg::MASK_W-1:0] fall,
                            input logic [renc_pkg::TICK_W-1:0] tick);
    send_pin_event({flags, rise, fall, tick});
  endtask

  task automatic wait_all_results;
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [renc_pkg::TICK_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == renc_pkg::REG_DEBOUNCE) window_ticks = val;
    else live_slots = val[renc_pkg::COUNT_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_registers(input logic [renc_pkg::TICK_W-1:0] window,
                               input logic [renc_pkg::COUNT_W-1:0] count);
    wait_all_results();
    write_register(renc_pkg::REG_DEBOUNCE, window);
    // junk above the count field must be dropped
    write_register(renc_pkg::REG_COUNT,
                   {8'($urandom_range(255, 0)), 20'h0, count} & 32'hFF00_000F);
  endtask

  task automatic check_encoder_steps;
    send_flags(EV_NONE, 8'h00, 8'h00, 32'h0);
    send_flags(EV_A_RISE, 8'h00, 8'h00, 32'h0);
    send_flags(EV_B_RISE, 8'h00, 8'h00, 32'h0);
    send_flags(EV_A_RISE, 8'h00, 8'h00, 32'h0);
    send_flags(EV_B_FALL | EV_B_HIGH, 8'h00, 8'h00, 32'h0);
    send_flags(EV_A_RISE | EV_B_HIGH, 8'h00, 8'h00, 32'h0);
    send_flags(EV_B_RISE | EV_B_HIGH, 8'h00, 8'h00, 32'h0);
    send_flags(EV_A_FALL | EV_B_HIGH, 8'h00, 8'h00, 32'h0);
    send_flags(EV_B_RISE | EV_B_FALL, 8'h00, 8'h00, 32'h0);
    send_flags(EV_A_FALL, 8'h00, 8'h00, 32'h0);
    // all flags at once: only the a rise acts and the flag ends disarmed
    send_flags(EV_B_RISE, 8'h00, 8'h00, 32'h0);
    send_flags(5'b11111, 8'h00, 8'h00, 32'h0);
    send_flags(EV_A_FALL, 8'h00, 8'h00, 32'h0);
    // a fall hides a b edge in the same item
    send_flags(EV_A_FALL | EV_B_RISE, 8'h00, 8'h00, 32'h0);
    send_flags(EV_A_RISE, 8'h00, 8'h00, 32'h0);
  endtask

  task automatic check_switch_debounce;
    send_flags(EV_NONE, 8'h00, 8'hFF, 32'd20);
    send_flags(EV_NONE, 8'h00, 8'hFF, 32'd21);
    send_flags(EV_NONE, 8'h0F, 8'h00, 32'd41);
    send_flags(EV_NONE, 8'h0F, 8'h00, 32'd42);
    send_flags(EV_NONE, 8'hFF, 8'hFF, 32'd100);
    // rise rejected by the window, fall not tried
    send_flags(EV_NONE, 8'hFF, 8'hFF, 32'd110);
    send_flags(EV_NONE, 8'h00, 8'hAA, TICK_MAX);
    // stamp plus window wraps past zero
    send_flags(EV_NONE, 8'hAA, 8'h00, 32'd25);
  endtask

  task automatic check_slot_count_and_window;
    set_registers(32'd20, 4'd0);
    send_flags(EV_NONE, 8'h00, 8'hFF, 32'd1000);
    set_registers(32'd20, 4'd3);
    send_flags(EV_NONE, 8'h00, 8'hFF, 32'd2000);
    set_registers(32'd20, 4'd15);
    send_flags(EV_NONE, 8'hFF, 8'h00, 32'd3000);
    set_registers(32'd20, 4'd9);
    send_flags(EV_NONE, 8'h00, 8'hFF, 32'd4000);
    set_registers(32'd0, 4'd8);
    send_flags(EV_NONE, 8'h01, 8'h00, 32'd4000);
    send_flags(EV_NONE, 8'h01, 8'h00, 32'd4001);
    set_registers(TICK_MAX, 4'd8);
    send_flags(EV_NONE, 8'h00, 8'h01, 32'd4001);
    send_flags(EV_NONE, 8'h02, 8'h00, 32'd3999);
  endtask

  function automatic logic [renc_pkg::MASK_W-1:0] pick_mask();
    case ($urandom_range(3, 0))
      0: return '0;
      1: return 8'h01 << $urandom_range(7, 0);
      2: return 8'($urandom);
      default: return 8'($urandom & $urandom);
    endcase
  endfunction

  function automatic logic [renc_pkg::TICK_W-1:0] step_tick();
    if ($urandom_range(99) < 5) tick_now = $urandom;
    else tick_now = tick_now + $urandom_range(40, 0);
    return tick_now;
  endfunction

  task automatic run_traffic_phase(input logic [renc_pkg::TICK_W-1:0] window,
                                   input logic [renc_pkg::COUNT_W-1:0] count,
                                   input int items, input bit hold_off);
    int sent = 0;
    logic [4:0] flags;
    set_registers(window, count);
    while (sent < items) begin
      if (hold_off && sent == items / 2) wait_all_results();
      if ($urandom_range(99) < 75) begin
        // one quadrature detent: a b edge then an a edge
        flags = ($urandom_range(1) ? EV_B_RISE : EV_B_FALL) |
                ($urandom_range(1) ? EV_B_HIGH : EV_NONE);
        send_flags(flags, pick_mask(), pick_mask(), step_tick());
        flags = ($urandom_range(1) ? EV_A_RISE : EV_A_FALL) |
                ($urandom_range(1) ? EV_B_HIGH : EV_NONE);
        send_flags(flags, pick_mask(), pick_mask(), step_tick());
        sent += 2;
      end else begin
        send_flags(5'($urandom_range(31, 0)), pick_mask(), pick_mask(), step_tick());
        sent++;
      end
    end
  endtask

  task automatic check_random_traffic;
    run_traffic_phase(32'd20, 4'd8, 72, 1'b0);
    run_traffic_phase($urandom_range(60, 1), 4'($urandom_range(15, 0)), 72, 1'b1);
    no_idle = 1'b1;
    run_traffic_phase(32'd0, 4'd8, 72, 1'b0);
    no_idle = 1'b0;
    run_traffic_phase(TICK_MAX, 4'd8, 72, 1'b0);
    run_traffic_phase($urandom, 4'd15, 72, 1'b0);
    run_traffic_phase(32'd7, 4'd4, 72, 1'b0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = renc_pkg::REG_DEBOUNCE;
    cfg_wdata = '0;
    knob_pos = renc_pkg::POS_RESET;
    knob_armed = 1'b0;
    slot_level = '0;
    for (int c = 0; c < SLOTS; c++) slot_stamp[c] = '0;
    window_ticks = renc_pkg::DEBOUNCE_RESET;
    live_slots = renc_pkg::COUNT_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    check_encoder_steps();
    check_switch_debounce();
    check_slot_count_and_window();
    check_random_traffic();
    wait_all_results();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/renc_pkg.sv
hdl/renc_quad.sv
hdl/renc_debounce.sv
hdl/rotary_encoder_with_switch_debounce.sv
sim/tb_rotary_encoder_with_switch_debounce.sv
